FILE: rtl/tun_pkg.sv
package tun_pkg;

  localparam int CoordW = 32;
  localparam int DiffW  = 33;
  localparam int ProdW  = 66;
  localparam int CrossW = 67;
  localparam int MagW   = 66;
  localparam int ScW    = 31;
  localparam int SumW   = 64;
  localparam int LenW   = 32;
  localparam int NrmW   = 16;
  localparam int QW     = 15;
  localparam int ShW    = 7;
  localparam logic [QW-1:0] UnitQ = 15'd16384;

  typedef struct packed {
    logic [ScW-1:0] s_x;
    logic [ScW-1:0] s_y;
    logic [ScW-1:0] s_z;
    logic           neg_x;
    logic           neg_y;
    logic           neg_z;
    logic           degen;
  } scaled_t;

  typedef struct packed {
    logic [NrmW-1:0] n_x;
    logic [NrmW-1:0] n_y;
    logic [NrmW-1:0] n_z;
    logic            degen;
  } result_t;

endpackage

FILE: rtl/tun_cross.sv
// Edge vectors, cross product, magnitude, common scale to 31 bits.
// Four register stages.
module tun_cross
  import tun_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_v,
  input  logic signed [CoordW-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
  output logic                     out_v,
  output scaled_t                  out_d
);

  // stage 1: differences
  logic signed [DiffW-1:0] ux_r, uy_r, uz_r, vx_r, vy_r, vz_r;
  // stage 2: products
  logic signed [ProdW-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  // stage 3: magnitudes
  logic [MagW-1:0] m_r [3];
  logic [2:0]      ng_r;
  // stage 4 output
  scaled_t         d_r;
  logic [3:0]      v_r;

  logic signed [CrossW-1:0] cr [3];
  logic [MagW-1:0]          mg [3];
  logic [MagW-1:0]          orv;
  logic [ShW-1:0]           k;

  always_comb begin
    cr[0] = CrossW'(p0_r) - CrossW'(p1_r);
    cr[1] = CrossW'(p2_r) - CrossW'(p3_r);
    cr[2] = CrossW'(p4_r) - CrossW'(p5_r);
    for (int i = 0; i < 3; i++) begin
      mg[i] = cr[i][CrossW-1] ? MagW'(-cr[i]) : MagW'(cr[i]);
    end
  end

  always_comb begin
    orv = m_r[0] | m_r[1] | m_r[2];
    k = '0;
    for (int j = ScW; j < MagW; j++) begin
      if (orv[j]) k = ShW'(j - ScW + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r <= DiffW'(b_x) - DiffW'(a_x);
      uy_r <= DiffW'(b_y) - DiffW'(a_y);
      uz_r <= DiffW'(b_z) - DiffW'(a_z);
      vx_r <= DiffW'(c_x) - DiffW'(a_x);
      vy_r <= DiffW'(c_y) - DiffW'(a_y);
      vz_r <= DiffW'(c_z) - DiffW'(a_z);
      p0_r <= uy_r * vz_r;
      p1_r <= uz_r * vy_r;
      p2_r <= uz_r * vx_r;
      p3_r <= ux_r * vz_r;
      p4_r <= ux_r * vy_r;
      p5_r <= uy_r * vx_r;
      for (int i = 0; i < 3; i++) begin
        m_r[i] <= mg[i];
        ng_r[i] <= cr[i][CrossW-1];
      end
      d_r.s_x   <= ScW'(m_r[0] >> k);
      d_r.s_y   <= ScW'(m_r[1] >> k);
      d_r.s_z   <= ScW'(m_r[2] >> k);
      d_r.neg_x <= ng_r[0];
      d_r.neg_y <= ng_r[1];
      d_r.neg_z <= ng_r[2];
      d_r.degen <= (orv == '0);
    end
  end

  assign out_v = v_r[3];
  assign out_d = d_r;

endmodule

FILE: rtl/tun_norm.sv
// Sum of squares, pipelined square root (one result bit per stage),
// pipelined restoring divide per component (one quotient bit per stage).
module tun_norm
  import tun_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    in_v,
  input  scaled_t in_d,
  output logic    out_v,
  output result_t out_d
);

  localparam int SqSt  = LenW;
  localparam int DvSt  = QW + 1;
  localparam int Depth = 2 + SqSt + DvSt + 1;

  // squares and sum
  logic [SumW-1:0] sq_r [3];
  scaled_t         a_r, b_r;
  logic [SumW-1:0] sum_r;

  // sqrt stages: remainder, root
  logic [SumW-1:0] rem_r [SqSt+1];
  logic [LenW-1:0] rt_r  [SqSt+1];
  scaled_t         sd_r  [SqSt+1];

  // divide stages: numerator rem per component, quotient
  localparam int RW = LenW + 2;
  logic [RW-1:0]   dr_r [DvSt+1][3];
  logic [QW:0]     dq_r [DvSt+1][3];
  logic [ScW+QW+1:0] dn_r [DvSt+1][3];
  logic [LenW:0]   dl_r [DvSt+1];
  scaled_t         dd_r [DvSt+1];

  result_t         res_r;
  logic [Depth-1:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[Depth-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0] <= SumW'(in_d.s_x) * SumW'(in_d.s_x);
      sq_r[1] <= SumW'(in_d.s_y) * SumW'(in_d.s_y);
      sq_r[2] <= SumW'(in_d.s_z) * SumW'(in_d.s_z);
      a_r     <= in_d;
      sum_r   <= sq_r[0] + sq_r[1] + sq_r[2];
      b_r     <= a_r;
    end
  end

  assign rem_r[0] = sum_r;
  assign rt_r[0]  = '0;
  assign sd_r[0]  = b_r;

  for (genvar g = 0; g < SqSt; g++) begin : g_sq
    localparam int B = SqSt - 1 - g;
    logic [SumW+1:0] trial;
    logic [SumW-1:0] rem_nxt;
    logic [LenW-1:0] rt_nxt;
    always_comb begin
      trial = ((SumW+2)'(rt_r[g]) << (B + 1)) + ((SumW+2)'(1) << (2 * B));
      if ((SumW+2)'(rem_r[g]) >= trial) begin
        rem_nxt = rem_r[g] - SumW'(trial);
        rt_nxt  = rt_r[g] | (LenW'(1) << B);
      end else begin
        rem_nxt = rem_r[g];
        rt_nxt  = rt_r[g];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g+1] <= rem_nxt;
        rt_r[g+1]  <= rt_nxt;
        sd_r[g+1]  <= sd_r[g];
      end
    end
  end

  // divide setup: numerator = 2*s*16384 + L, divisor = 2L; quotient <= 16384
  always_comb begin
    logic [LenW:0] l;
    l = (rt_r[SqSt] == '0) ? (LenW+1)'(1) : (LenW+1)'(rt_r[SqSt]);
    dl_r[0] = l << 1;
    dd_r[0] = sd_r[SqSt];
    dn_r[0][0] = ((ScW+QW+2)'(sd_r[SqSt].s_x) << (QW)) + (ScW+QW+2)'(l);
    dn_r[0][1] = ((ScW+QW+2)'(sd_r[SqSt].s_y) << (QW)) + (ScW+QW+2)'(l);
    dn_r[0][2] = ((ScW+QW+2)'(sd_r[SqSt].s_z) << (QW)) + (ScW+QW+2)'(l);
    for (int c = 0; c < 3; c++) begin
      dr_r[0][c] = RW'(dn_r[0][c] >> DvSt);
      dq_r[0][c] = '0;
    end
  end

  for (genvar g = 0; g < DvSt; g++) begin : g_dv
    localparam int B = DvSt - 1 - g;
    logic [RW-1:0] r_nxt [3];
    logic [QW:0]   q_nxt [3];
    logic [RW:0]   t [3];
    always_comb begin
      for (int c = 0; c < 3; c++) begin
        t[c] = {dr_r[g][c], dn_r[g][c][B]};
        if (t[c] >= (RW+1)'(dl_r[g])) begin
          r_nxt[c] = RW'(t[c] - (RW+1)'(dl_r[g]));
          q_nxt[c] = dq_r[g][c] | ((QW+1)'(1) << B);
        end else begin
          r_nxt[c] = RW'(t[c]);
          q_nxt[c] = dq_r[g][c];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dr_r[g+1] <= r_nxt;
        dq_r[g+1] <= q_nxt;
        dn_r[g+1] <= dn_r[g];
        dl_r[g+1] <= dl_r[g];
        dd_r[g+1] <= dd_r[g];
      end
    end
  end

  // The remainder enters the divide holding the numerator bits above the
  // quotient range; each step brings in one more numerator bit.
  function automatic logic [NrmW-1:0] apply_sign(logic [QW:0] q, logic ng);
    logic [QW-1:0] qc;
    qc = (q > (QW+1)'(UnitQ)) ? UnitQ : QW'(q);
    return ng ? -NrmW'(qc) : NrmW'(qc);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      if (dd_r[DvSt].degen) begin
        res_r.n_x <= '0;
        res_r.n_y <= '0;
        res_r.n_z <= NrmW'(UnitQ);
      end else begin
        res_r.n_x <= apply_sign(dq_r[DvSt][0], dd_r[DvSt].neg_x);
        res_r.n_y <= apply_sign(dq_r[DvSt][1], dd_r[DvSt].neg_y);
        res_r.n_z <= apply_sign(dq_r[DvSt][2], dd_r[DvSt].neg_z);
      end
      res_r.degen <= dd_r[DvSt].degen;
    end
  end

  assign out_v = v_r[Depth-1];
  assign out_d = res_r;

endmodule

FILE: rtl/triangle_unit_normal.sv
// Triangle unit normal.
// Input channel: nine signed Q16.16 corner coordinates (a, b, c) per
// transfer on in_valid/in_ready. Output channel: signed Q2.14 unit normal
// and a degenerate flag per transfer on out_valid/out_ready.
// The normal is (b-a) x (c-a), scaled to 31-bit magnitudes, divided by the
// integer square root of its squared length and rounded to nearest.
// A zero cross product gives (0,0,1) with degenerate set.
// Pipeline: cross product and scaling, squaring and sum, square root (one
// root bit per stage), division (one quotient bit per stage) and an output
// register.
// Throughput: one transfer per cycle unless the output stalls; the pipeline
// depth and the one-bit square root and divide stages set the latency.
// Reset clears every valid bit and holds in_ready low; payload registers
// are not reset.
// When out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated.
module triangle_unit_normal
  import tun_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [CoordW-1:0] in_a_x, in_a_y, in_a_z,
  input  logic signed [CoordW-1:0] in_b_x, in_b_y, in_b_z,
  input  logic signed [CoordW-1:0] in_c_x, in_c_y, in_c_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [NrmW-1:0]   out_normal_x,
  output logic signed [NrmW-1:0]   out_normal_y,
  output logic signed [NrmW-1:0]   out_normal_z,
  output logic                     out_degenerate
);

  logic    en;
  logic    x_v;
  scaled_t x_d;
  result_t r_d;

  // pipeline advances unless the output holds an untaken result
  assign en       = out_ready || !out_valid;
  assign in_ready = en && rst_n;

  tun_cross u_cross (
    .clk, .rst_n, .en,
    .in_v (in_valid),
    .a_x (in_a_x), .a_y (in_a_y), .a_z (in_a_z),
    .b_x (in_b_x), .b_y (in_b_y), .b_z (in_b_z),
    .c_x (in_c_x), .c_y (in_c_y), .c_z (in_c_z),
    .out_v (x_v),
    .out_d (x_d)
  );

  tun_norm u_norm (
    .clk, .rst_n, .en,
    .in_v  (x_v),
    .in_d  (x_d),
    .out_v (out_valid),
    .out_d (r_d)
  );

  assign out_normal_x   = r_d.n_x;
  assign out_normal_y   = r_d.n_y;
  assign out_normal_z   = r_d.n_z;
  assign out_degenerate = r_d.degen;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(r_d))
    else $error("result changed under stall");

  // degenerate result is the default normal
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_normal_x == 0 && out_normal_y == 0 &&
      out_normal_z == NrmW'(UnitQ))
    else $error("bad default normal");

  // z component stays in unit range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_normal_z <= 16384 && out_normal_z >= -16384)
    else $error("normal out of range");

endmodule

FILE: sim/tb_triangle_unit_normal.sv
`timescale 1ns / 1ps

module tb_triangle_unit_normal;
  import tun_pkg::*;

  localparam int LatencyCycles = 55;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CoordW-1:0] in_a_x = '0, in_a_y = '0, in_a_z = '0;
  logic signed [CoordW-1:0] in_b_x = '0, in_b_y = '0, in_b_z = '0;
  logic signed [CoordW-1:0] in_c_x = '0, in_c_y = '0, in_c_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [NrmW-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_degenerate;

  // Idle/stall probabilities in percent, changed per phase
  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  result_t normals_due[$];

  triangle_unit_normal DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver backpressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Golden normal: exact cross product in 128 bits, shift to 31-bit
  // magnitudes, bitwise integer sqrt, round-to-nearest divide.
  function automatic result_t face_normal(input logic signed [CoordW-1:0] p [9]);
    logic signed [127:0] u [3];
    logic signed [127:0] v [3];
    logic signed [127:0] n [3];
    logic [127:0] m [3];
    logic neg [3];
    logic [63:0] s [3];
    logic [63:0] sum, rem, bitv, root, q;
    logic [NrmW-1:0] comp [3];
    int k;
    result_t r;
    for (int i = 0; i < 3; i++) begin
      u[i] = 128'(p[3+i]) - 128'(p[i]);
      v[i] = 128'(p[6+i]) - 128'(p[i]);
    end
    n[0] = u[1] * v[2] - u[2] * v[1];
    n[1] = u[2] * v[0] - u[0] * v[2];
    n[2] = u[0] * v[1] - u[1] * v[0];
    for (int i = 0; i < 3; i++) begin
      neg[i] = n[i][127];
      m[i] = neg[i] ? -n[i] : n[i];
    end
    if ((m[0] | m[1] | m[2]) == '0) begin
      r.n_x = '0;
      r.n_y = '0;
      r.n_z = NrmW'(UnitQ);
      r.degen = 1'b1;
      return r;
    end
    k = 0;
    while ((m[0] >> k) >= (128'd1 << 31) || (m[1] >> k) >= (128'd1 << 31) ||
           (m[2] >> k) >= (128'd1 << 31))
      k++;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      s[i] = 64'(m[i] >> k);
      sum += s[i] * s[i];
    end
    root = '0;
    rem = sum;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    if (root == 0) root = 1;
    for (int i = 0; i < 3; i++) begin
      q = (2 * s[i] * 16384 + root) / (2 * root);
      if (q > 16384) q = 16384;
      comp[i] = neg[i] ? -q[NrmW-1:0] : q[NrmW-1:0];
    end
    r.n_x = comp[0];
    r.n_y = comp[1];
    r.n_z = comp[2];
    r.degen = 1'b0;
    return r;
  endfunction

  // One triangle: optional random gap, then hold valid until transfer
  task automatic send_triangle(input logic signed [CoordW-1:0] p [9]);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_a_x, in_a_y, in_a_z} <= {p[0], p[1], p[2]};
    {in_b_x, in_b_y, in_b_z} <= {p[3], p[4], p[5]};
    {in_c_x, in_c_y, in_c_z} <= {p[6], p[7], p[8]};
    do @(posedge clk); while (!in_ready);
    normals_due = {normals_due, face_normal(p)};
  endtask

  // Wait until every queued normal has come back, then let the pipe settle
  task automatic drain_normals();
    in_valid <= 1'b0;
    while (normals_due.size() != 0) @(posedge clk);
    repeat (LatencyCycles + 5) @(posedge clk);
  endtask

  // Scoreboard: every output transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (normals_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected normal %0d %0d %0d deg=%0b",
                   out_normal_x, out_normal_y, out_normal_z, out_degenerate);
      end else begin
        result_t want;
        want = normals_due.pop_front();
        if (out_normal_x !== want.n_x || out_normal_y !== want.n_y ||
            out_normal_z !== want.n_z || out_degenerate !== want.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("normal mismatch: exp %0d %0d %0d deg=%0b got %0d %0d %0d deg=%0b",
                     $signed(want.n_x), $signed(want.n_y), $signed(want.n_z), want.degen,
                     out_normal_x, out_normal_y, out_normal_z, out_degenerate);
        end
      end
    end
  end

  // Corners with full 32-bit random coordinates
  task automatic rand_corners(output logic signed [CoordW-1:0] p [9]);
    for (int i = 0; i < 9; i++) p[i] = $urandom;
  endtask

  // Random triangle: half ordinary meshes, some collinear, some with coincident corners, the rest full-range
  task automatic mixed_triangle(output logic signed [CoordW-1:0] p [9]);
    int pick, t;
    pick = $urandom_range(99);
    rand_corners(p);
    if (pick < 50) begin
      // mesh-sized coordinates, up to +-256.0
      for (int i = 0; i < 9; i++)
        p[i] = $signed($urandom_range(33554431)) - 32'sd16777216;
    end else if (pick < 60) begin
      // collinear: c = a + t*(b-a), degenerate
      for (int i = 0; i < 3; i++) begin
        p[i] = $signed($urandom_range(65535)) - 32'sd32768;
        p[3+i] = p[i] + $signed($urandom_range(4095)) - 32'sd2048;
      end
      t = $urandom_range(8) - 4;
      for (int i = 0; i < 3; i++) p[6+i] = p[i] + t * (p[3+i] - p[i]);
    end else if (pick < 65) begin
      // coincident corners
      p[3] = p[0]; p[4] = p[1]; p[5] = p[2];
    end
    // else full range noise
  endtask

  task automatic test_directed();
    logic signed [CoordW-1:0] p [9];
    logic signed [CoordW-1:0] mx, mn;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    idle_pct = 0;
    stall_pct = 0;
    // unit right triangle in xy plane
    p = '{0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000, 0};
    send_triangle(p);
    // reversed winding
    p = '{0, 0, 0, 0, 32'sh10000, 0, 32'sh10000, 0, 0};
    send_triangle(p);
    // yz and zx planes
    p = '{0, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
    send_triangle(p);
    p = '{0, 0, 0, 0, 0, 32'sh10000, 32'sh10000, 0, 0};
    send_triangle(p);
    // all corners equal, all zero
    p = '{default: 0};
    send_triangle(p);
    // all corners at the extremes, equal
    p = '{default: mx};
    send_triangle(p);
    p = '{default: mn};
    send_triangle(p);
    // collinear
    p = '{0, 0, 0, 1, 2, 3, 2, 4, 6};
    send_triangle(p);
    // largest edge vectors: full-scale cross product
    p = '{mn, mn, mn, mx, mn, mn, mn, mx, mn};
    send_triangle(p);
    p = '{mn, mn, mn, mx, mx, mn, mn, mx, mx};
    send_triangle(p);
    p = '{mx, mn, mx, mn, mx, mn, mx, mx, mn};
    send_triangle(p);
    p = '{mn, mx, mn, mx, mn, mx, mx, mx, mx};
    send_triangle(p);
    // smallest nonzero cross product
    p = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_triangle(p);
    // diagonal normal, equal components (rounding on 1/sqrt(3))
    p = '{32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
    send_triangle(p);
    // one tiny component beside huge ones, lost in the shift
    p = '{0, 0, 0, mx, 1, 0, 0, mx, 1};
    send_triangle(p);
    p = '{0, 0, 0, mx, 0, 1, 1, mx, 0};
    send_triangle(p);
    // 3-4-5 style normal
    p = '{0, 0, 0, 3, 0, 0, 0, 4, 5};
    send_triangle(p);
    p = '{-5, 7, -9, 11, -13, 17, -19, 23, -29};
    send_triangle(p);
    drain_normals();
  endtask

  task automatic test_random_phase(input int n_items, input int gap, input int stall);
    logic signed [CoordW-1:0] p [9];
    idle_pct = gap;
    stall_pct = stall;
    for (int i = 0; i < n_items; i++) begin
      mixed_triangle(p);
      send_triangle(p);
    end
    drain_normals();
  endtask

  // Sender stops mid-stream until everything is back, then resumes
  task automatic test_pause_resume();
    logic signed [CoordW-1:0] p [9];
    idle_pct = 10;
    stall_pct = 30;
    for (int i = 0; i < 40; i++) begin
      mixed_triangle(p);
      send_triangle(p);
    end
    drain_normals();
    for (int i = 0; i < 40; i++) begin
      mixed_triangle(p);
      send_triangle(p);
    end
    drain_normals();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(200, 0, 0);
    test_random_phase(200, 56, 0);
    test_random_phase(200, 0, 56);
    test_random_phase(200, 20, 20);
    test_pause_resume();
    if (mismatches == 0 && normals_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
